/* design/pitb_pkg.sv */
// Package with the default sizes of the point-in-triangle core.
package pitb_pkg;
    localparam int PITB_COORD_BITS       = 16;
    localparam int PITB_WEIGHT_FRAC_BITS = 16;
endpackage

/* design/pitb_if.sv */
// Handshake interfaces for the query channel and the result channel.
interface pitb_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] vert1_x;
    logic signed [COORD_BITS-1:0] vert1_y;
    logic signed [COORD_BITS-1:0] vert2_x;
    logic signed [COORD_BITS-1:0] vert2_y;
    logic signed [COORD_BITS-1:0] vert3_x;
    logic signed [COORD_BITS-1:0] vert3_y;
    modport source (output valid, query_x, query_y, vert1_x, vert1_y, vert2_x, vert2_y,
                    vert3_x, vert3_y, input ready);
    modport sink   (input valid, query_x, query_y, vert1_x, vert1_y, vert2_x, vert2_y,
                    vert3_x, vert3_y, output ready);
endinterface

interface pitb_out_if #(parameter int WEIGHT_FRAC_BITS = 16);
    logic                      valid;
    logic                      ready;
    logic                      inside_res;
    logic [WEIGHT_FRAC_BITS:0] weight_first;
    logic [WEIGHT_FRAC_BITS:0] weight_second;
    logic [WEIGHT_FRAC_BITS:0] weight_third;
    modport source (output valid, inside_res, weight_first, weight_second, weight_third,
                    input ready);
    modport sink   (input valid, inside_res, weight_first, weight_second, weight_third,
                    output ready);
endinterface

/* design/pitb_front.sv */
// Front pipeline: translation, products, signed areas with tie-break, sum and magnitudes.
module pitb_front
    import pitb_pkg::*;
#(
    parameter int  COORD_BITS = PITB_COORD_BITS,
    parameter type t_bus      = logic
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    input  logic signed [COORD_BITS-1:0] i_vx [3],
    input  logic signed [COORD_BITS-1:0] i_vy [3],
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_bus                         o_bus
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int AW = PW + 1;
    localparam int SW = AW + 1;
    localparam int NS = 5;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    // Stage 0: coordinates relative to the query point.
    logic signed [DW-1:0] r_dx0 [3], r_dy0 [3];
    // Stage 1: the two cross products of each area.
    logic signed [PW-1:0] r_ml [3], r_mr [3];
    logic signed [DW-1:0] r_dx1 [3], r_dy1 [3];
    // Stage 2: areas and their signs.
    logic signed [AW-1:0] r_area [3];
    logic                 r_pre2;
    // Stage 3: sum and area magnitudes.
    logic signed [SW-1:0] r_sum;
    logic [SW-1:0]        r_mag [3];
    logic                 r_pre3;
    // Stage 4: bus towards the divider.
    t_bus                 r_bus;

    assign w_rdy[NS] = i_ready;
    for (genvar s = 0; s < NS; s++) begin : g_rdy
        assign w_rdy[s] = !r_v[s] || w_rdy[s+1];
    end
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_bus   = r_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_rdy[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    logic                 w_pos [3], w_neg [3];
    logic signed [AW-1:0] w_area [3];

    for (genvar k = 0; k < 3; k++) begin : g_area
        localparam int P = (k + 1) % 3;
        localparam int Q = (k + 2) % 3;

        always_comb begin
            w_area[k] = {r_ml[k][PW-1], r_ml[k]} - {r_mr[k][PW-1], r_mr[k]};
            if (w_area[k] != '0) begin
                w_pos[k] = !w_area[k][AW-1];
                w_neg[k] = w_area[k][AW-1];
            end else if (r_dy1[Q] != r_dy1[P]) begin
                w_pos[k] = r_dy1[Q] > r_dy1[P];
                w_neg[k] = r_dy1[Q] < r_dy1[P];
            end else begin
                w_pos[k] = r_dx1[P] > r_dx1[Q];
                w_neg[k] = r_dx1[P] < r_dx1[Q];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[0]) begin
                r_dx0[k] <= {i_vx[k][COORD_BITS-1], i_vx[k]} - {i_qx[COORD_BITS-1], i_qx};
                r_dy0[k] <= {i_vy[k][COORD_BITS-1], i_vy[k]} - {i_qy[COORD_BITS-1], i_qy};
            end
            if (w_rdy[1]) begin
                r_ml[k]  <= r_dy0[P] * r_dx0[Q];
                r_mr[k]  <= r_dx0[P] * r_dy0[Q];
                r_dx1[k] <= r_dx0[k];
                r_dy1[k] <= r_dy0[k];
            end
            if (w_rdy[2]) begin
                r_area[k] <= w_area[k];
            end
            if (w_rdy[3]) begin
                r_mag[k] <= r_area[k][AW-1] ? SW'(-{r_area[k][AW-1], r_area[k]})
                                            : SW'({r_area[k][AW-1], r_area[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_pre2 <= (w_pos[0] && w_pos[1] && w_pos[2]) || (w_neg[0] && w_neg[1] && w_neg[2]);
        end
        if (w_rdy[3]) begin
            r_sum  <= {r_area[0][AW-1], r_area[0]} + {r_area[1][AW-1], r_area[1]}
                    + {r_area[2][AW-1], r_area[2]};
            r_pre3 <= r_pre2;
        end
        if (w_rdy[4]) begin
            r_bus.in_tri <= r_pre3 && (r_sum != '0);
            r_bus.den    <= r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
            for (int k = 0; k < 3; k++) begin
                r_bus.rem[k] <= r_mag[k];
                r_bus.quo[k] <= '0;
            end
        end
    end
endmodule

/* design/pitb_div_cell.sv */
// One restoring-division cell: develops one quotient bit of all three weights.
module pitb_div_cell #(
    parameter int  SW    = 36,
    parameter int  QW    = 17,
    parameter bit  FIRST = 1'b0,
    parameter type t_bus = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_bus i_bus,
    output logic o_valid,
    input  logic i_ready,
    output t_bus o_bus
);
    logic r_v;
    t_bus r_bus;
    t_bus w_bus;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_bus   = r_bus;

    always_comb begin
        logic [SW-1:0] t;
        logic          ge;
        w_bus = i_bus;
        for (int j = 0; j < 3; j++) begin
            t  = FIRST ? i_bus.rem[j] : {i_bus.rem[j][SW-2:0], 1'b0};
            ge = t >= i_bus.den;
            w_bus.rem[j] = ge ? t - i_bus.den : t;
            w_bus.quo[j] = {i_bus.quo[j][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_bus <= w_bus;
        end
    end
endmodule

/* design/point_in_triangle_barycentric_core.sv */
// Top level of the pipelined point-in-triangle test with barycentric weights.
// Each transfer on i_in carries a query point and three triangle vertices as signed
// COORD_BITS-bit coordinates; each transfer on o_out returns one result: inside_res and
// three unsigned Q1.WEIGHT_FRAC_BITS weights, all zero when the point is outside. A
// point counts as inside when the three sub-areas, with zero areas resolved by a
// symbolic-perturbation tie-break, share one nonzero sign and their sum is nonzero.
// The core accepts one query every cycle while no stage is stalled by backpressure; it
// has five front stages (translation, products, areas, sum, magnitude) followed
// by a chain of WEIGHT_FRAC_BITS + 1 division cells, each producing one quotient bit.
// Every stage holds its data under backpressure, so the core keeps filling bubbles
// while a result waits at the output register.
module point_in_triangle_barycentric_core
    import pitb_pkg::*;
#(
    parameter int COORD_BITS       = PITB_COORD_BITS,
    parameter int WEIGHT_FRAC_BITS = PITB_WEIGHT_FRAC_BITS
) (
    input logic      i_clk,
    input logic      i_rst_n,
    pitb_in_if.sink  i_in,
    pitb_out_if.source o_out
);
    localparam int SW = 2 * (COORD_BITS + 1) + 2;
    localparam int QW = WEIGHT_FRAC_BITS + 1;

    // Data handed from cell to cell: divisor, three partial remainders and quotients.
    typedef struct packed {
        logic                 in_tri;
        logic [SW-1:0]        den;
        logic [2:0][SW-1:0]   rem;
        logic [2:0][QW-1:0]   quo;
    } t_bus;

    logic signed [COORD_BITS-1:0] w_vx [3], w_vy [3];
    assign w_vx[0] = i_in.vert1_x;
    assign w_vy[0] = i_in.vert1_y;
    assign w_vx[1] = i_in.vert2_x;
    assign w_vy[1] = i_in.vert2_y;
    assign w_vx[2] = i_in.vert3_x;
    assign w_vy[2] = i_in.vert3_y;

    logic w_valid [QW+1];
    logic w_ready [QW+1];
    t_bus w_bus   [QW+1];

    pitb_front #(.COORD_BITS(COORD_BITS), .t_bus(t_bus)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_qx    (i_in.query_x),
        .i_qy    (i_in.query_y),
        .i_vx    (w_vx),
        .i_vy    (w_vy),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_bus   (w_bus[0])
    );

    // The first cell compares the magnitude itself, to catch a weight of exactly one;
    // every later cell doubles the remainder first.
    for (genvar i = 0; i < QW; i++) begin : g_cell
        pitb_div_cell #(.SW(SW), .QW(QW), .FIRST(i == 0), .t_bus(t_bus)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[i]),
            .o_ready (w_ready[i]),
            .i_bus   (w_bus[i]),
            .o_valid (w_valid[i+1]),
            .i_ready (w_ready[i+1]),
            .o_bus   (w_bus[i+1])
        );
    end

    // An outside result shows zero weights; the divisor may have been zero there.
    assign w_ready[QW]         = o_out.ready;
    assign o_out.valid         = w_valid[QW];
    assign o_out.inside_res    = w_bus[QW].in_tri;
    assign o_out.weight_first  = w_bus[QW].in_tri ? w_bus[QW].quo[0] : '0;
    assign o_out.weight_second = w_bus[QW].in_tri ? w_bus[QW].quo[1] : '0;
    assign o_out.weight_third  = w_bus[QW].in_tri ? w_bus[QW].quo[2] : '0;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.inside_res) |->
        (o_out.weight_first == '0 && o_out.weight_second == '0 && o_out.weight_third == '0))
        else $error("outside result with nonzero weights");

    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.inside_res) |->
        ((QW + 2)'(o_out.weight_first) + (QW + 2)'(o_out.weight_second)
         + (QW + 2)'(o_out.weight_third) <= ((QW + 2)'(1) << WEIGHT_FRAC_BITS)))
        else $error("weights sum above one");
endmodule
